/* hdl/wfslm_pkg.sv */
// ----------------------------------------------------------------------------
// wfslm_pkg
// Shared constants, twiddle and window tables, and controller/datapath types
// for the windowed spectrum level meter.
// ----------------------------------------------------------------------------
package wfslm_pkg;

   localparam int FRAME_SIZE   = 128;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_W       = $clog2(FRAME_SIZE);
   localparam int NUM_BINS     = FRAME_SIZE / 2;
   localparam int BIN_W        = 6;
   localparam int MAG_W        = 16;
   localparam int LEVEL_W      = 16;
   localparam int WIN_W        = SAMPLE_BITS + 1;
   localparam int HANN_W       = 17;
   localparam int TWID_W       = 32;
   localparam int PROD_W       = WIN_W + TWID_W;
   localparam int ACC_W        = PROD_W + ADDR_W + 1;
   localparam int ENERGY_W     = 2 * SAMPLE_BITS + ADDR_W - 1;
   localparam int EXP_W        = $clog2(ENERGY_W);
   localparam int LOG_OFFSET   = ADDR_W + 2 * (SAMPLE_BITS - 1);
   localparam int MANT_W       = 31;
   localparam int FRAC_W       = 16;
   localparam int LOG_STEPS    = 16;
   localparam int NEG_W        = EXP_W + FRAC_W;
   localparam int LVL_K_W      = 18;
   localparam int LVL_PROD_W   = NEG_W + LVL_K_W;
   localparam int MAG_SHIFT    = ADDR_W + SAMPLE_BITS + 3;
   localparam int COMP_W       = 24;
   localparam int SUMSQ_W      = 2 * COMP_W + 1;
   localparam int ROOT_W       = SUMSQ_W + 1;
   localparam int ROOT_STEPS   = (SUMSQ_W + 1) / 2;
   localparam int CNT_W        = $clog2(ROOT_STEPS);

   localparam logic [LVL_K_W-1:0]        TEN_LOG10_2_Q16 = 18'd197283;
   localparam logic signed [LEVEL_W-1:0] SILENCE_DB      = -16'sd15360;
   localparam logic [LEVEL_W-1:0]        FLOOR_DB        = 16'd28672;
   localparam logic [63:0]               PI_Q30          = 64'd3373259426;
   localparam logic [63:0]               ONE_Q30         = 64'd1073741824;

   typedef logic [FRAME_SIZE-1:0][TWID_W-1:0] twid_tab_type;
   typedef logic [FRAME_SIZE-1:0][HANN_W-1:0] hann_tab_type;

   function automatic logic [63:0] quarter_sine(input logic [63:0] g);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (g * PI_Q30) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         unique case (k)
            1:       term = term / 6;
            2:       term = term / 20;
            3:       term = term / 42;
            4:       term = term / 72;
            5:       term = term / 110;
            6:       term = term / 156;
            default: term = term / 210;
         endcase
         if ((k & 1) == 1) sum = sum - term;
         else              sum = sum + term;
      end
      if (sum > ONE_Q30) sum = ONE_Q30;
      return sum;
   endfunction

   function automatic logic [63:0] cos_turn(input logic [31:0] t);
      logic [63:0] f;
      logic [63:0] rf;
      logic [63:0] res;
      f  = {34'd0, t[29:0]};
      rf = ONE_Q30 - f;
      unique case (t[31:30])
         2'd0:    res = quarter_sine(rf);
         2'd1:    res = 64'd0 - quarter_sine(f);
         2'd2:    res = 64'd0 - quarter_sine(rf);
         default: res = quarter_sine(f);
      endcase
      return res;
   endfunction

   function automatic logic [31:0] turn_frame(input logic [31:0] m);
      logic [63:0] num;
      logic [63:0] q;
      num = {m, 32'd0};
      q   = num / FRAME_SIZE;
      return q[31:0];
   endfunction

   function automatic logic [31:0] turn_hann(input logic [31:0] m);
      logic [63:0] num;
      logic [63:0] q;
      num = {m, 32'd0};
      q   = num / (FRAME_SIZE - 1);
      return q[31:0];
   endfunction

   function automatic twid_tab_type make_cos();
      twid_tab_type tab;
      logic [63:0]  c;
      for (int i = 0; i < FRAME_SIZE; i++) begin
         c      = cos_turn(turn_frame(32'(i)));
         tab[i] = c[TWID_W-1:0];
      end
      return tab;
   endfunction

   function automatic twid_tab_type make_sin();
      twid_tab_type tab;
      logic [63:0]  c;
      for (int i = 0; i < FRAME_SIZE; i++) begin
         c      = cos_turn(turn_frame(32'(i)) - 32'h4000_0000);
         tab[i] = c[TWID_W-1:0];
      end
      return tab;
   endfunction

   function automatic hann_tab_type make_hann();
      hann_tab_type tab;
      logic [63:0]  c;
      logic [63:0]  h;
      for (int i = 0; i < FRAME_SIZE; i++) begin
         c      = cos_turn(turn_hann(32'(i)));
         h      = (ONE_Q30 - c + 64'd16384) >> 15;
         tab[i] = h[HANN_W-1:0];
      end
      return tab;
   endfunction

   localparam twid_tab_type COS_TAB  = make_cos();
   localparam twid_tab_type SIN_TAB  = make_sin();
   localparam hann_tab_type HANN_TAB = make_hann();

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_LOG_LOAD,
      ST_LOG_NORM,
      ST_SQ_MUL,
      ST_SQ_UPD,
      ST_LVL_MUL,
      ST_LVL_FIN,
      ST_BIN_START,
      ST_MAC,
      ST_DRAIN,
      ST_MAG_LOAD,
      ST_MAG_SQ,
      ST_MAG_SUM,
      ST_ROOT,
      ST_EMIT
   } wfslm_state_type;

   typedef struct packed {
      logic              sample_wr;
      logic              log_load;
      logic              log_shift;
      logic              sq_init;
      logic              sq_mul;
      logic              sq_upd;
      logic              lvl_mul;
      logic              lvl_fin;
      logic              acc_clear;
      logic              mac_issue;
      logic              mag_load;
      logic              mag_sq;
      logic              mag_sum;
      logic              root_step;
      logic [ADDR_W-1:0] addr;
      logic [BIN_W-1:0]  bin;
   } wfslm_cmd_type;

   typedef struct packed {
      logic energy_zero;
      logic norm_done;
      logic pipe_busy;
   } wfslm_status_type;

endpackage

/* hdl/wfslm_if.sv */
// ----------------------------------------------------------------------------
// wfslm request/response channels
// Valid/ready channels carrying one sample request and one bin response.
// ----------------------------------------------------------------------------
interface wfslm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wfslm_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         bin_index;
   logic [15:0]        magnitude;
   logic signed [15:0] level_db;
   logic               last_bin;

   modport source (output valid, output bin_index, output magnitude,
                   output level_db, output last_bin, input ready);
   modport sink   (input valid, input bin_index, input magnitude,
                   input level_db, input last_bin, output ready);
endinterface

/* hdl/wfslm_ctrl.sv */
// ----------------------------------------------------------------------------
// wfslm_ctrl
// Sequencer: frame collection, level log, per-bin DFT, root and emit.
// ----------------------------------------------------------------------------
module wfslm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  wfslm_pkg::wfslm_status_type status,
   output wfslm_pkg::wfslm_cmd_type    cmd
);
   import wfslm_pkg::*;

   wfslm_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] n_ff, n_in;
   logic [BIN_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         fill_ff  <= '0;
         n_ff     <= '0;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               fill_in = fill_ff + 1'b1;
               if (fill_ff == ADDR_W'(FRAME_SIZE - 1)) begin
                  state_in = ST_LOG_LOAD;
                  k_in     = '0;
               end
            end
         end
         ST_LOG_LOAD: begin
            cnt_in   = '0;
            state_in = status.energy_zero ? ST_BIN_START : ST_LOG_NORM;
         end
         ST_LOG_NORM: begin
            if (status.norm_done) state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: state_in = ST_SQ_UPD;
         ST_SQ_UPD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) begin
               state_in = ST_LVL_MUL;
            end else begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_LVL_MUL: state_in = ST_LVL_FIN;
         ST_LVL_FIN: state_in = ST_BIN_START;
         ST_BIN_START: begin
            n_in     = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            n_in = n_ff + 1'b1;
            if (n_ff == ADDR_W'(FRAME_SIZE - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_MAG_LOAD;
         end
         ST_MAG_LOAD: state_in = ST_MAG_SQ;
         ST_MAG_SQ:   state_in = ST_MAG_SUM;
         ST_MAG_SUM: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (k_ff == BIN_W'(NUM_BINS - 1)) begin
                  state_in = ST_COLLECT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_BIN_START;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.bin   = k_ff;
      cmd.addr  = (state_ff == ST_COLLECT) ? fill_ff : n_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready     = 1'b1;
            cmd.sample_wr = req_valid;
         end
         ST_LOG_LOAD: cmd.log_load = 1'b1;
         ST_LOG_NORM: begin
            cmd.sq_init   = status.norm_done;
            cmd.log_shift = !status.norm_done;
         end
         ST_SQ_MUL:    cmd.sq_mul    = 1'b1;
         ST_SQ_UPD:    cmd.sq_upd    = 1'b1;
         ST_LVL_MUL:   cmd.lvl_mul   = 1'b1;
         ST_LVL_FIN:   cmd.lvl_fin   = 1'b1;
         ST_BIN_START: cmd.acc_clear = 1'b1;
         ST_MAC:       cmd.mac_issue = 1'b1;
         ST_DRAIN:     cmd.mag_load  = 1'b0;
         ST_MAG_LOAD:  cmd.mag_load  = 1'b1;
         ST_MAG_SQ:    cmd.mag_sq    = 1'b1;
         ST_MAG_SUM:   cmd.mag_sum   = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_EMIT:      rsp_valid     = 1'b1;
         default:      cmd.bin       = k_ff;
      endcase
   end

endmodule

/* hdl/wfslm_datapath.sv */
// ----------------------------------------------------------------------------
// wfslm_datapath
// Window/energy on intake, log2 level unit, MAC pipeline over the windowed
// frame memory, and bit-serial magnitude root.
// ----------------------------------------------------------------------------
module wfslm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  wfslm_pkg::wfslm_cmd_type          cmd,
   output wfslm_pkg::wfslm_status_type       status,
   input  logic signed [wfslm_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic [wfslm_pkg::BIN_W-1:0]       rsp_bin_index,
   output logic [wfslm_pkg::MAG_W-1:0]       rsp_magnitude,
   output logic signed [wfslm_pkg::LEVEL_W-1:0] rsp_level_db,
   output logic                              rsp_last_bin
);
   import wfslm_pkg::*;

   // windowed frame memory
   logic signed [WIN_W-1:0] work_mem [FRAME_SIZE];

   // intake
   logic signed [SAMPLE_BITS+HANN_W:0] win_prod;
   logic [SAMPLE_BITS+HANN_W:0]        win_abs;
   logic [SAMPLE_BITS+HANN_W:0]        win_rnd;
   logic signed [WIN_W-1:0]            win_val;
   logic signed [2*SAMPLE_BITS-1:0]    sq_sample;
   logic [ENERGY_W-1:0]                energy_ff;

   // level unit
   logic [ENERGY_W-1:0]    norm_ff;
   logic [EXP_W-1:0]       exp_ff;
   logic [MANT_W-1:0]      mant_ff;
   logic [FRAC_W-1:0]      frac_ff;
   logic [2*MANT_W-1:0]    msq_ff;
   logic [MANT_W:0]        msq_top;
   logic [EXP_W-1:0]       exp_diff;
   logic [NEG_W-1:0]       neg_val;
   logic [LVL_PROD_W-1:0]  lvl_prod_ff;
   logic [LVL_PROD_W-1:0]  lvl_rnd;
   logic [LVL_PROD_W-25:0] db_val;
   logic [LEVEL_W-1:0]     db_clamp;
   logic signed [LEVEL_W-1:0] level_ff;

   // MAC pipeline
   logic [ADDR_W-1:0]        phase_ff;
   logic [ADDR_W-1:0]        idx_ff;
   logic signed [WIN_W-1:0]  rd_ff;
   logic signed [WIN_W-1:0]  x1_ff;
   logic signed [TWID_W-1:0] c1_ff;
   logic signed [TWID_W-1:0] s1_ff;
   logic signed [PROD_W-1:0] pc_ff;
   logic signed [PROD_W-1:0] ps_ff;
   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [ACC_W-1:0]  acc_re_ff;
   logic signed [ACC_W-1:0]  acc_im_ff;

   // magnitude
   logic [ACC_W-1:0]    abs_re;
   logic [ACC_W-1:0]    abs_im;
   logic [COMP_W-1:0]   rr_ff, ri_ff;
   logic                sat_ff;
   logic [2*COMP_W-1:0] sqa_ff, sqb_ff;
   logic [ROOT_W-1:0]   v_ff, r_ff, bit_ff;
   logic [ROOT_W-1:0]   trial;

   assign win_prod = req_sample * $signed({1'b0, HANN_TAB[cmd.addr]});
   assign win_abs  = win_prod[SAMPLE_BITS+HANN_W] ? (SAMPLE_BITS+HANN_W+1)'(-win_prod)
                                                  : win_prod;
   assign win_rnd  = (win_abs + (SAMPLE_BITS+HANN_W+1)'(32768)) >> 16;
   assign win_val  = win_prod[SAMPLE_BITS+HANN_W] ? -$signed(win_rnd[WIN_W-1:0])
                                                  : $signed(win_rnd[WIN_W-1:0]);
   assign sq_sample = req_sample * req_sample;

   always_ff @(posedge clock) begin
      if (cmd.sample_wr) work_mem[cmd.addr] <= win_val;
      if (cmd.mac_issue) rd_ff <= work_mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
      end else if (cmd.log_load) begin
         energy_ff <= '0;
      end else if (cmd.sample_wr) begin
         energy_ff <= energy_ff + ENERGY_W'($unsigned(sq_sample));
      end
   end

   // log2 level
   assign msq_top  = msq_ff[2*MANT_W-1:30];
   assign exp_diff = EXP_W'(LOG_OFFSET) - exp_ff;
   assign neg_val  = (exp_ff == EXP_W'(LOG_OFFSET)) ? '0
                     : {exp_diff, {FRAC_W{1'b0}}} - NEG_W'(frac_ff);
   assign lvl_rnd  = lvl_prod_ff + LVL_PROD_W'(1 << 23);
   assign db_val   = lvl_rnd[LVL_PROD_W-1:24];
   assign db_clamp = (db_val > (LVL_PROD_W-24)'(FLOOR_DB)) ? FLOOR_DB
                                                           : db_val[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.log_load) begin
         norm_ff <= energy_ff;
         exp_ff  <= EXP_W'(ENERGY_W - 1);
         if (energy_ff == '0) level_ff <= SILENCE_DB;
      end
      if (cmd.log_shift) begin
         norm_ff <= norm_ff << 1;
         exp_ff  <= exp_ff - 1'b1;
      end
      if (cmd.sq_init) begin
         mant_ff <= norm_ff[ENERGY_W-1 -: MANT_W];
         frac_ff <= '0;
      end
      if (cmd.sq_mul) msq_ff <= mant_ff * mant_ff;
      if (cmd.sq_upd) begin
         mant_ff <= msq_top[MANT_W] ? msq_top[MANT_W:1] : msq_top[MANT_W-1:0];
         frac_ff <= {frac_ff[FRAC_W-2:0], msq_top[MANT_W]};
      end
      if (cmd.lvl_mul) lvl_prod_ff <= neg_val * TEN_LOG10_2_Q16;
      if (cmd.lvl_fin) level_ff <= $signed(LEVEL_W'(-db_clamp));
   end

   // MAC pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         phase_ff  <= '0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v3_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(pc_ff);
         acc_im_ff <= acc_im_ff - ACC_W'(ps_ff);
      end
      if (cmd.mac_issue) begin
         idx_ff   <= phase_ff;
         phase_ff <= phase_ff + cmd.bin[ADDR_W-2:0];
      end
      x1_ff <= rd_ff;
      c1_ff <= $signed(COS_TAB[idx_ff]);
      s1_ff <= $signed(SIN_TAB[idx_ff]);
      pc_ff <= x1_ff * c1_ff;
      ps_ff <= x1_ff * s1_ff;
   end

   // magnitude and root
   assign abs_re = acc_re_ff[ACC_W-1] ? ACC_W'(-acc_re_ff) : acc_re_ff;
   assign abs_im = acc_im_ff[ACC_W-1] ? ACC_W'(-acc_im_ff) : acc_im_ff;
   assign trial  = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.mag_load) begin
         rr_ff  <= abs_re[MAG_SHIFT +: COMP_W];
         ri_ff  <= abs_im[MAG_SHIFT +: COMP_W];
         sat_ff <= (abs_re[ACC_W-1:MAG_SHIFT+COMP_W] != '0)
                || (abs_im[ACC_W-1:MAG_SHIFT+COMP_W] != '0);
      end
      if (cmd.mag_sq) begin
         sqa_ff <= rr_ff * rr_ff;
         sqb_ff <= ri_ff * ri_ff;
      end
      if (cmd.mag_sum) begin
         v_ff   <= ROOT_W'(sqa_ff) + ROOT_W'(sqb_ff);
         r_ff   <= '0;
         bit_ff <= ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
      end
      if (cmd.root_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign status.energy_zero = (energy_ff == '0);
   assign status.norm_done   = norm_ff[ENERGY_W-1];
   assign status.pipe_busy   = v1_ff | v2_ff | v3_ff;

   assign rsp_bin_index = cmd.bin;
   assign rsp_last_bin  = (cmd.bin == BIN_W'(NUM_BINS - 1));
   assign rsp_level_db  = level_ff;
   assign rsp_magnitude = (sat_ff || (r_ff[ROOT_W-1:MAG_W+8] != '0)) ? {MAG_W{1'b1}}
                                                                     : r_ff[MAG_W+7:8];

endmodule

/* hdl/windowed_fft_spectrum_level_meter_core.sv */
// ----------------------------------------------------------------------------
// windowed_fft_spectrum_level_meter_core
// Hann-windowed spectrum and RMS level meter over frames of 128 samples.
//
//   channel   dir   payload                                   per frame
//   req_chan  in    sample                                    128 requests
//   rsp_chan  out   bin_index, magnitude, level_db, last_bin   64 responses
//
// Samples are taken one per cycle while a frame fills; the frame is then
// processed with req_chan.ready low. Each bin passes in turn through the single
// MAC unit, a magnitude load, the bit-serial root and the emit.
// Synchronous reset clears control and the energy sum; a stalled response
// holds the sequencer in place with its payload stable.
// ----------------------------------------------------------------------------
module windowed_fft_spectrum_level_meter_core (
   input logic       clock,
   input logic       reset,
   wfslm_req_if.sink   req_chan,
   wfslm_rsp_if.source rsp_chan
);
   import wfslm_pkg::*;

   wfslm_cmd_type    cmd;
   wfslm_status_type status;

   wfslm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wfslm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_sample    (req_chan.sample),
      .rsp_bin_index (rsp_chan.bin_index),
      .rsp_magnitude (rsp_chan.magnitude),
      .rsp_level_db  (rsp_chan.level_db),
      .rsp_last_bin  (rsp_chan.last_bin)
   );

endmodule

/* tb/sv/wfslm_tb_if.sv */
// ----------------------------------------------------------------------------
// wfslm testbench channel note
// The block's channel interfaces live with the RTL (wfslm_if.sv); this file
// carries the testbench-side bin result record used by the top module.
// ----------------------------------------------------------------------------
package wfslm_tb_pkg;

   typedef struct {
      logic [5:0]         bin_index;
      logic [15:0]        magnitude;
      logic signed [15:0] level_db;
      logic               last_bin;
   } bin_result_type;

endpackage

/* tb/sv/windowed_fft_spectrum_level_meter_core_tb.sv */
// ----------------------------------------------------------------------------
// windowed_fft_spectrum_level_meter_core_tb
// Feeds 128-sample frames, predicts the Hann-windowed bin magnitudes and the
// frame level in integer arithmetic, and checks every bin response in order
// under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module windowed_fft_spectrum_level_meter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wfslm_pkg::*;
   import wfslm_tb_pkg::*;

   localparam int LIMIT = 4_000_000;

   class spectrum_scoreboard;
      longint cos_q30[FRAME_SIZE];
      longint sin_q30[FRAME_SIZE];
      longint hann_q16[FRAME_SIZE];
      longint frame_buf[FRAME_SIZE];
      longint unsigned energy;
      int fill;
      bin_result_type pending_bins[$];
      int errors;
      int frames;
      int checked;

      function longint quarter_wave(longint unsigned g);
         longint unsigned x, x2, term, acc;
         x = (g * 64'd3373259426) >> 31;
         x2 = (x * x) >> 30;
         term = x;
         acc = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1) acc -= term;
            else acc += term;
         end
         if (acc > 64'd1073741824) acc = 64'd1073741824;
         return longint'(acc);
      endfunction

      function longint cosine_of_turn(bit [31:0] t);
         longint unsigned f, rf;
         f = t[29:0];
         rf = 64'd1073741824 - f;
         case (t[31:30])
            2'd0: return quarter_wave(rf);
            2'd1: return -quarter_wave(f);
            2'd2: return -quarter_wave(rf);
            default: return quarter_wave(f);
         endcase
      endfunction

      function bit [31:0] phase_of(longint unsigned m, longint unsigned period);
         longint unsigned q;
         q = (m << 32) / period;
         return q[31:0];
      endfunction

      function longint unsigned log2_fixed(longint unsigned x);
         longint unsigned k, m, frac;
         k = 63;
         frac = 0;
         while (k > 0 && !x[k]) k--;
         m = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
         for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31)) begin
               m >>= 1;
               frac |= 1;
            end
         end
         return (k << 16) | frac;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function logic signed [15:0] level_of_frame();
         longint lq;
         longint unsigned db;
         if (energy == 0) return -16'sd15360;
         lq = longint'(log2_fixed(energy)) - longint'(log2_fixed(FRAME_SIZE)) - 30 * 65536;
         if (lq >= 0) return 16'sd0;
         db = (longint'(-lq) * 64'd197283 + (64'd1 << 23)) >> 24;
         if (db > 28672) db = 28672;
         return -$signed(16'(db));
      endfunction

      function logic [15:0] magnitude_of(longint re, longint im);
         longint unsigned dv, ar, ai, rr, ri, m;
         dv = longint'(FRAME_SIZE) << 19;
         ar = (re < 0) ? -re : re;
         ai = (im < 0) ? -im : im;
         rr = ar / dv;
         ri = ai / dv;
         if (rr >= (64'd1 << 24) || ri >= (64'd1 << 24)) return 16'hFFFF;
         m = int_sqrt(rr * rr + ri * ri) >> 8;
         return (m > 65535) ? 16'hFFFF : 16'(m);
      endfunction

      function new();
         for (int i = 0; i < FRAME_SIZE; i++) begin
            cos_q30[i] = cosine_of_turn(phase_of(i, FRAME_SIZE));
            sin_q30[i] = cosine_of_turn(phase_of(i, FRAME_SIZE) - 32'h4000_0000);
            hann_q16[i] = (longint'(64'd1073741824) - cosine_of_turn(phase_of(i, FRAME_SIZE - 1))
                           + 16384) >>> 15;
         end
         energy = 0;
         fill = 0;
         errors = 0;
         frames = 0;
         checked = 0;
      endfunction

      function void note_sample(logic signed [15:0] s);
         longint p, r, re, im;
         logic signed [15:0] lvl;
         bin_result_type b;
         frame_buf[fill] = s;
         energy += longint'(s) * longint'(s);
         fill++;
         if (fill < FRAME_SIZE) return;
         lvl = level_of_frame();
         for (int n = 0; n < FRAME_SIZE; n++) begin
            p = frame_buf[n] * hann_q16[n];
            r = (((p < 0) ? -p : p) + (1 << 15)) >>> 16;
            frame_buf[n] = (p < 0) ? -r : r;
         end
         for (int k = 0; k < NUM_BINS; k++) begin
            re = 0;
            im = 0;
            for (int n = 0; n < FRAME_SIZE; n++) begin
               re += frame_buf[n] * cos_q30[(k * n) % FRAME_SIZE];
               im -= frame_buf[n] * sin_q30[(k * n) % FRAME_SIZE];
            end
            b.bin_index = 6'(k);
            b.magnitude = magnitude_of(re, im);
            b.level_db = lvl;
            b.last_bin = (k == NUM_BINS - 1);
            pending_bins.push_back(b);
         end
         fill = 0;
         energy = 0;
         frames++;
      endfunction

      function void check_bin(bin_result_type got);
         bin_result_type want;
         checked++;
         if (pending_bins.size() == 0) begin
            $display("%0t: unexpected bin response %0d", $time, got.bin_index);
            errors++;
            return;
         end
         want = pending_bins.pop_front();
         if (got.bin_index !== want.bin_index) begin
            $display("%0t: bin_index exp %0d got %0d", $time, want.bin_index, got.bin_index);
            errors++;
         end
         if (got.magnitude !== want.magnitude) begin
            $display("%0t: bin %0d magnitude exp %0d got %0d", $time, want.bin_index,
                     want.magnitude, got.magnitude);
            errors++;
         end
         if (got.level_db !== want.level_db) begin
            $display("%0t: bin %0d level_db exp %0d got %0d", $time, want.bin_index,
                     want.level_db, got.level_db);
            errors++;
         end
         if (got.last_bin !== want.last_bin) begin
            $display("%0t: bin %0d last_bin exp %0b got %0b", $time, want.bin_index,
                     want.last_bin, got.last_bin);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   wfslm_req_if req_chan ();
   wfslm_rsp_if rsp_chan ();

   windowed_fft_spectrum_level_meter_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   spectrum_scoreboard board;
   int send_idle_pct;
   int stall_pct;
   int hold_off_cycles;
   longint cycle_count;
   logic signed [15:0] sample_q[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // response side: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_bin('{rsp_chan.bin_index, rsp_chan.magnitude, rsp_chan.level_db,
                              rsp_chan.last_bin});
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_frame(input logic signed [15:0] samples[$]);
      foreach (samples[i]) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.sample <= samples[i];
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         board.note_sample(samples[i]);
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending_bins.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample(int style);
      case (style)
         0: return $signed(16'($urandom));
         1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
         2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      endcase
   endfunction

   task automatic build_frame(input int kind, output logic signed [15:0] f[$]);
      int per;
      int amp;
      f = {};
      per = $urandom_range(2, 64);
      amp = $urandom_range(1, 32767);
      for (int i = 0; i < FRAME_SIZE; i++) begin
         case (kind)
            0: f.push_back(16'sd0);
            1: f.push_back(16'sh7FFF);
            2: f.push_back(16'sh8000);
            3: f.push_back((i % 2) ? 16'sh8000 : 16'sh7FFF);
            4: f.push_back((i == 5) ? 16'sd1 : 16'sd0);
            5: f.push_back(((i / per) % 2) ? 16'(-amp) : 16'(amp));
            6: f.push_back(pick_sample(1));
            7: f.push_back(pick_sample(2));
            8: f.push_back(pick_sample(3));
            default: f.push_back(pick_sample(0));
         endcase
      end
   endtask

   initial begin
      logic signed [15:0] fr[$];
      board = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // silence, no idling on either side
      build_frame(0, fr);
      send_frame(fr);
      drain();

      // negative full scale, sender gaps
      send_idle_pct = 47;
      build_frame(2, fr);
      send_frame(fr);

      // receiver stalls and a long hold-off while the next frame is offered
      send_idle_pct = 0;
      stall_pct = 47;
      hold_off_cycles = 30000;
      build_frame($urandom_range(5, 9), fr);
      send_frame(fr[0:15]);
      drain();

      // rest of the frame with both sides idling
      send_idle_pct = 37;
      stall_pct = 37;
      send_frame(fr[16:$]);
      drain();

      repeat (200) @(posedge clock);
      $display("tb: %0d frames sent, %0d bin responses checked (silence, full scale,",
               board.frames, board.checked);
      $display("tb: tone or noise; idle and stall mixes with a long hold-off)");
      if (board.errors == 0 && board.pending_bins.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/wfslm_pkg.sv
hdl/wfslm_if.sv
hdl/wfslm_ctrl.sv
hdl/wfslm_datapath.sv
hdl/windowed_fft_spectrum_level_meter_core.sv
tb/sv/wfslm_tb_if.sv
tb/sv/windowed_fft_spectrum_level_meter_core_tb.sv
